/* rtl/masmu_pkg.sv */
package masmu_pkg;

   // Operation codes carried in the op field of a request word.
   localparam logic [2:0] OP_WRITE_A = 3'd0;
   localparam logic [2:0] OP_WRITE_B = 3'd1;
   localparam logic [2:0] OP_READ_A  = 3'd2;
   localparam logic [2:0] OP_SUM     = 3'd3;
   localparam logic [2:0] OP_DIFF    = 3'd4;
   localparam logic [2:0] OP_PROD    = 3'd5;

   // Status codes carried in the status field of a response word.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_SAT   = 2'd2;

   // Saturation bounds of the 32-bit signed result.
   localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CMD,
      ST_READ,
      ST_MAC,
      ST_SAT,
      ST_FIN
   } masmu_state_type;

endpackage

/* rtl/masmu_ifs.sv */
// Request channel: one word per matrix operation.
interface masmu_req_if;
   import masmu_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [4:0]         row;
   logic [4:0]         col;
   logic signed [31:0] value;

   modport source (output valid, output op, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input op, input row, input col, input value,
                   output ready);
endinterface

// Response channel: one word per request word.
interface masmu_rsp_if;
   import masmu_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;
   logic [1:0]         status;

   modport source (output valid, output result, output status, input ready);
   modport sink   (input valid, input result, input status, output ready);
endinterface

/* rtl/masmu_ram.sv */
// Single-port-write, single-port-read matrix store with registered read data.
module masmu_ram
   import masmu_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  logic signed [31:0] wdata,
   input  logic [AW-1:0]      raddr,
   output logic signed [31:0] rdata
);

   logic signed [31:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

/* rtl/matrix_add_sub_multiply_unit.sv */
// Matrix add, subtract and multiply unit.
// Holds two DIM x DIM signed 32-bit matrices A and B in two on-chip memories.
// Each request word on req writes one element of A or B, reads one element of
// A, or reads element (row,col) of A+B, A-B or A*B. Each request word yields
// exactly one response word on rsp carrying the result and a status code
// (ok, index out of range, or saturated to the 32-bit signed range).
// Requests are taken one at a time. After acceptance a write or an out-of-range
// request passes through ST_CMD and ST_FIN; an element read, sum or difference
// through ST_CMD, ST_READ and ST_FIN; a product through ST_CMD, ST_MAC, ST_SAT and
// ST_FIN. The product time is set by the dot-product loop, which reads one element
// of A and one of B per cycle through the memory read ports and feeds one multiplier.
// The response word is loaded into the output register in ST_FIN, once the
// output register is free.
// The response sits in an output register, so a new request is accepted while
// an earlier response waits; when rsp is stalled the sequencer holds its
// finished result until the output register frees up.
// After reset the block runs a clearing pass over all DIM * DIM entries that loads
// both matrices with the identity; req.ready stays low during that pass.
module matrix_add_sub_multiply_unit
   import masmu_pkg::*;
#(
   parameter int DIM = 16
) (
   input  logic        clock,
   input  logic        reset,
   masmu_req_if.sink   req,
   masmu_rsp_if.source rsp
);

   localparam int DEPTH = DIM * DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CW    = $clog2(DIM + 1);
   localparam int ACC_W = 65 + $clog2(DIM);

   masmu_state_type state_ff, state_in;

   // Latched request word.
   logic [2:0]         req_op_ff;
   logic [4:0]         req_row_ff;
   logic [4:0]         req_col_ff;
   logic signed [31:0] req_value_ff;

   // Clearing pass counters.
   logic [IW-1:0] clr_row_ff, clr_row_in;
   logic [IW-1:0] clr_col_ff, clr_col_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Dot-product loop.
   logic [AW-1:0]          a_addr_ff, a_addr_in;
   logic [AW-1:0]          b_addr_ff, b_addr_in;
   logic [CW-1:0]          iss_cnt_ff, iss_cnt_in;
   logic                   issue;
   logic                   rd_valid_ff;
   logic                   prod_valid_ff;
   logic signed [63:0]     prod_ff;
   logic signed [63:0]     prod_w;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Finished result, then output register.
   logic signed [31:0] res_ff, res_in;
   logic [1:0]         stat_ff, stat_in;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_result_ff;
   logic [1:0]         rsp_status_ff;
   logic               load_out;

   // Memory ports.
   logic               we_a, we_b;
   logic [AW-1:0]      waddr;
   logic signed [31:0] wdata;
   logic [AW-1:0]      raddr_a, raddr_b;
   logic signed [31:0] rd_a, rd_b;

   // Address and range decode of the latched request.
   logic [9:0]         elem_wide;
   logic [9:0]         base_wide;
   logic [AW-1:0]      elem_addr;
   logic               out_of_range;
   logic signed [32:0] sum_w;
   logic signed [32:0] diff_w;
   logic               acc_fits;

   assign base_wide    = 10'(req_row_ff) * 10'(DIM);
   assign elem_wide    = base_wide + 10'(req_col_ff);
   assign elem_addr    = elem_wide[AW-1:0];
   assign out_of_range = ({1'b0, req_row_ff} >= 6'(DIM)) || ({1'b0, req_col_ff} >= 6'(DIM));

   assign sum_w    = {rd_a[31], rd_a} + {rd_b[31], rd_b};
   assign diff_w   = {rd_a[31], rd_a} - {rd_b[31], rd_b};
   assign prod_w   = rd_a * rd_b;
   assign acc_fits = (&acc_ff[ACC_W-1:31]) || !(|acc_ff[ACC_W-1:31]);

   assign req.ready = (state_ff == ST_IDLE);
   assign load_out  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp.ready);

   masmu_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_a),
      .rdata (rd_a)
   );

   masmu_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_b),
      .rdata (rd_b)
   );

   // State register and control counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_row_ff    <= '0;
         clr_col_ff    <= '0;
         clr_addr_ff   <= '0;
         iss_cnt_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_row_ff    <= clr_row_in;
         clr_col_ff    <= clr_col_in;
         clr_addr_ff   <= clr_addr_in;
         iss_cnt_ff    <= iss_cnt_in;
         rd_valid_ff   <= issue;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   // Payload registers of the datapath.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_op_ff    <= req.op;
         req_row_ff   <= req.row;
         req_col_ff   <= req.col;
         req_value_ff <= req.value;
      end
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      prod_ff   <= prod_w;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
   end

   // Output register; it frees up when the receiver takes the word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_result_ff <= res_ff;
         rsp_status_ff <= stat_ff;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.result = rsp_result_ff;
   assign rsp.status = rsp_status_ff;

   // Sequencer: next state, memory controls and loop counters.
   // Items run one at a time, so a write always lands before any later read.
   always_comb begin
      state_in    = state_ff;
      clr_row_in  = clr_row_ff;
      clr_col_in  = clr_col_ff;
      clr_addr_in = clr_addr_ff;
      a_addr_in   = a_addr_ff;
      b_addr_in   = b_addr_ff;
      iss_cnt_in  = iss_cnt_ff;
      issue       = 1'b0;
      acc_in      = acc_ff;
      res_in      = res_ff;
      stat_in     = stat_ff;
      we_a        = 1'b0;
      we_b        = 1'b0;
      waddr       = elem_addr;
      wdata       = req_value_ff;
      raddr_a     = elem_addr;
      raddr_b     = elem_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            // Load the identity, one entry of each matrix per cycle.
            we_a        = 1'b1;
            we_b        = 1'b1;
            waddr       = clr_addr_ff;
            wdata       = 32'(clr_row_ff == clr_col_ff);
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_col_ff == IW'(DIM - 1)) begin
               clr_col_in = '0;
               clr_row_in = clr_row_ff + IW'(1);
               if (clr_row_ff == IW'(DIM - 1)) begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_col_in = clr_col_ff + IW'(1);
            end
         end

         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_CMD;
            end
         end

         ST_CMD: begin
            res_in  = '0;
            stat_in = STAT_OK;
            if (out_of_range) begin
               stat_in  = STAT_RANGE;
               state_in = ST_FIN;
            end else begin
               case (req_op_ff) inside
                  OP_WRITE_A: begin
                     we_a     = 1'b1;
                     state_in = ST_FIN;
                  end
                  OP_WRITE_B: begin
                     we_b     = 1'b1;
                     state_in = ST_FIN;
                  end
                  OP_READ_A, OP_SUM, OP_DIFF: begin
                     state_in = ST_READ;
                  end
                  OP_PROD: begin
                     a_addr_in  = base_wide[AW-1:0];
                     b_addr_in  = AW'(req_col_ff);
                     iss_cnt_in = '0;
                     acc_in     = '0;
                     state_in   = ST_MAC;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_READ: begin
            // Element data from both memories is valid in this cycle.
            case (req_op_ff)
               OP_SUM: begin
                  if (sum_w[32] != sum_w[31]) begin
                     res_in  = sum_w[32] ? RES_MIN : RES_MAX;
                     stat_in = STAT_SAT;
                  end else begin
                     res_in = sum_w[31:0];
                  end
               end
               OP_DIFF: begin
                  if (diff_w[32] != diff_w[31]) begin
                     res_in  = diff_w[32] ? RES_MIN : RES_MAX;
                     stat_in = STAT_SAT;
                  end else begin
                     res_in = diff_w[31:0];
                  end
               end
               default: begin
                  res_in = rd_a;
               end
            endcase
            state_in = ST_FIN;
         end

         ST_MAC: begin
            // Issue one A/B read pair per cycle; multiply, then accumulate.
            raddr_a = a_addr_ff;
            raddr_b = b_addr_ff;
            if (iss_cnt_ff != CW'(DIM)) begin
               issue      = 1'b1;
               iss_cnt_in = iss_cnt_ff + CW'(1);
               a_addr_in  = a_addr_ff + AW'(1);
               b_addr_in  = b_addr_ff + AW'(DIM);
            end
            if (prod_valid_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if ((iss_cnt_ff == CW'(DIM)) && !rd_valid_ff && !prod_valid_ff) begin
               state_in = ST_SAT;
            end
         end

         ST_SAT: begin
            if (acc_fits) begin
               res_in = acc_ff[31:0];
            end else begin
               res_in  = acc_ff[ACC_W-1] ? RES_MIN : RES_MAX;
               stat_in = STAT_SAT;
            end
            state_in = ST_FIN;
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/masmu_chk.sv */
// Port-level checks of the matrix unit.
module masmu_chk
   import masmu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_result,
   input logic [1:0]         rsp_status
);

   // Reset starts the clearing pass, so no word is taken right after it.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request taken or response shown right after reset");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while one is in progress");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // A rejected index carries a zero result.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_RANGE) |-> rsp_result == 32'sd0)
      else $error("out-of-range response with nonzero result");

   // A saturated result sits at one of the bounds.
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_SAT) |-> (rsp_result == RES_MAX) || (rsp_result == RES_MIN))
      else $error("saturated response not at a bound");

endmodule

bind matrix_add_sub_multiply_unit masmu_chk u_masmu_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_result (rsp.result),
   .rsp_status (rsp.status)
);

/* verif/matrix_add_sub_multiply_unit_test.sv */
module matrix_add_sub_multiply_unit_test;
   import masmu_pkg::*;

   localparam int DIM = 16;
   localparam int INDEX_MAX = 31;
   localparam int RANDOM_WORDS = 1850;
   localparam int PAUSE_AT = 900;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * DIM + 16;

   // Op codes that the block leaves unused.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic signed [31:0] result;
      logic [1:0]         status;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [4:0]         row;
      logic [4:0]         col;
      logic signed [31:0] value;
      logic               typed;
      logic signed [31:0] result;
      logic [1:0]         status;
   } req_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   masmu_req_if req_ch ();
   masmu_rsp_if rsp_ch ();

   matrix_add_sub_multiply_unit #(.DIM(DIM)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copies of both matrices and the responses still owed by the block.
   logic signed [31:0] shadow_a [DIM][DIM];
   logic signed [31:0] shadow_b [DIM][DIM];
   rsp_word_type       pending_words [$];
   req_row_type        directed_rows [$];
   int                 fail_count = 0;
   int                 cycle_count = 0;

   always #10 clock = ~clock;

   // Clamp an exact value to the signed 32-bit range.
   function automatic rsp_word_type clamp_word(input logic signed [69:0] wide);
      rsp_word_type w;
      if (wide > RES_MAX) begin
         w.result = RES_MAX;
         w.status = STAT_SAT;
      end else if (wide < RES_MIN) begin
         w.result = RES_MIN;
         w.status = STAT_SAT;
      end else begin
         w.result = wide[31:0];
         w.status = STAT_OK;
      end
      return w;
   endfunction

   // Apply one request word to the shadow matrices and return its response.
   function automatic rsp_word_type predict_element(input logic [2:0] op,
                                                    input logic [4:0] row,
                                                    input logic [4:0] col,
                                                    input logic signed [31:0] value);
      rsp_word_type       w;
      logic signed [69:0] wide;
      logic signed [63:0] term;
      w.result = '0;
      w.status = STAT_OK;
      if (row >= DIM || col >= DIM) begin
         w.status = STAT_RANGE;
         return w;
      end
      case (op)
         OP_WRITE_A: shadow_a[row][col] = value;
         OP_WRITE_B: shadow_b[row][col] = value;
         OP_READ_A:  w.result = shadow_a[row][col];
         OP_SUM: begin
            wide = shadow_a[row][col] + shadow_b[row][col];
            w = clamp_word(wide);
         end
         OP_DIFF: begin
            wide = shadow_a[row][col] - shadow_b[row][col];
            w = clamp_word(wide);
         end
         OP_PROD: begin
            wide = '0;
            for (int k = 0; k < DIM; k++) begin
               term = shadow_a[row][k] * shadow_b[k][col];
               wide = wide + term;
            end
            w = clamp_word(wide);
         end
         default: ;
      endcase
      return w;
   endfunction

   // Present one request word and hold it until the block takes it.
   task automatic send_word(input req_row_type w);
      rsp_word_type predicted;
      req_ch.valid <= 1'b1;
      req_ch.op    <= w.op;
      req_ch.row   <= w.row;
      req_ch.col   <= w.col;
      req_ch.value <= w.value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_element(w.op, w.row, w.col, w.value);
      if (w.typed)
         pending_words.push_back({w.result, w.status});
      else
         pending_words.push_back(predicted);
   endtask

   // Random request word, weighted toward in-range indices and mixed magnitudes.
   function automatic req_row_type random_word();
      req_row_type w;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 22)      w.op = OP_WRITE_A;
      else if (pick < 44) w.op = OP_WRITE_B;
      else if (pick < 54) w.op = OP_READ_A;
      else if (pick < 64) w.op = OP_SUM;
      else if (pick < 74) w.op = OP_DIFF;
      else if (pick < 94) w.op = OP_PROD;
      else if (pick < 97) w.op = OP_SPARE_6;
      else                w.op = OP_SPARE_7;
      w.row = 5'($urandom_range(0, DIM - 1));
      w.col = 5'($urandom_range(0, DIM - 1));
      pick = $urandom_range(0, 19);
      if (pick == 0) w.row = 5'($urandom_range(DIM, INDEX_MAX));
      if (pick == 1) w.col = 5'($urandom_range(DIM, INDEX_MAX));
      if (pick == 2) begin
         w.row = 5'($urandom_range(DIM, INDEX_MAX));
         w.col = 5'($urandom_range(DIM, INDEX_MAX));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5)       w.value = $signed(32'($urandom_range(0, 2000))) - 1000;
      else if (pick < 7)  w.value = $urandom;
      else if (pick == 7) w.value = RES_MAX;
      else if (pick == 8) w.value = RES_MIN;
      else                w.value = $signed($urandom) >>> 17;
      w.typed  = 1'b0;
      w.result = '0;
      w.status = STAT_OK;
      return w;
   endfunction

   // Cycle counter with the run's timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response checker and receiver stall pattern.
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $error("response word with none expected: result %0d, status %0d",
                   rsp_ch.result, rsp_ch.status);
            fail_count++;
         end else begin
            exp_word = pending_words.pop_front();
            if (rsp_ch.result !== exp_word.result) begin
               $error("result mismatch: expected %0d, actual %0d",
                      exp_word.result, rsp_ch.result);
               fail_count++;
            end
            if (rsp_ch.status !== exp_word.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      exp_word.status, rsp_ch.status);
               fail_count++;
            end
         end
      end
      // Three stall modes in turn: always ready, random stalls, periodic stalls.
      case ((cycle_count / 2500) % 3)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ch.ready <= ((cycle_count % 11) < 4);
      endcase
   end

   // Stimulus: directed table, then random bursts.
   initial begin
      int burst_left;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_WRITE_A;
      req_ch.row   <= '0;
      req_ch.col   <= '0;
      req_ch.value <= '0;

      // Both matrices start out as the identity.
      for (int i = 0; i < DIM; i++)
         for (int j = 0; j < DIM; j++) begin
            shadow_a[i][j] = (i == j) ? 32'sd1 : 32'sd0;
            shadow_b[i][j] = (i == j) ? 32'sd1 : 32'sd0;
         end

      // Reads of the identity after reset.
      directed_rows.push_back(req_row_type'{OP_READ_A, 5'd0, 5'd0, 32'sd0, 1'b1, 32'sd1,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_READ_A, 5'd0, 5'd1, 32'sd0, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_PROD, 5'd3, 5'd3, 32'sd0, 1'b1, 32'sd1,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_SUM, 5'd5, 5'd5, 32'sd0, 1'b1, 32'sd2,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_DIFF, 5'd15, 5'd15, 32'sd0, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_READ_A, 5'd15, 5'd14, 32'sd0, 1'b1, 32'sd0,
                                            STAT_OK});
      // Extreme values and saturation in both directions.
      directed_rows.push_back(req_row_type'{OP_WRITE_A, 5'd0, 5'd0, RES_MAX, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_WRITE_B, 5'd0, 5'd0, RES_MAX, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_SUM, 5'd0, 5'd0, 32'sd0, 1'b1, RES_MAX,
                                            STAT_SAT});
      directed_rows.push_back(req_row_type'{OP_PROD, 5'd0, 5'd0, 32'sd0, 1'b0, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_WRITE_B, 5'd0, 5'd0, RES_MIN, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_DIFF, 5'd0, 5'd0, 32'sd0, 1'b1, RES_MAX,
                                            STAT_SAT});
      directed_rows.push_back(req_row_type'{OP_WRITE_A, 5'd0, 5'd0, RES_MIN, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_SUM, 5'd0, 5'd0, 32'sd0, 1'b1, RES_MIN,
                                            STAT_SAT});
      directed_rows.push_back(req_row_type'{OP_READ_A, 5'd0, 5'd0, 32'sd0, 1'b1, RES_MIN,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_PROD, 5'd0, 5'd0, 32'sd0, 1'b0, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_WRITE_A, 5'd0, 5'd1, -32'sd7, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_PROD, 5'd0, 5'd1, 32'sd0, 1'b0, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_WRITE_B, 5'd15, 5'd0, RES_MAX, 1'b1, 32'sd0,
                                            STAT_OK});
      // Indices out of range, which must write nothing.
      directed_rows.push_back(req_row_type'{OP_WRITE_A, 5'(DIM), 5'd0, 32'sd5, 1'b1, 32'sd0,
                                            STAT_RANGE});
      directed_rows.push_back(req_row_type'{OP_READ_A, 5'd0, 5'(DIM), 32'sd0, 1'b1, 32'sd0,
                                            STAT_RANGE});
      directed_rows.push_back(req_row_type'{OP_SUM, 5'd31, 5'd31, 32'sd0, 1'b1, 32'sd0,
                                            STAT_RANGE});
      // Unused op codes, in range and out of range.
      directed_rows.push_back(req_row_type'{OP_SPARE_6, 5'd1, 5'd1, -32'sd1, 1'b1, 32'sd0,
                                            STAT_OK});
      directed_rows.push_back(req_row_type'{OP_SPARE_7, 5'd31, 5'd0, 32'sd0, 1'b1, 32'sd0,
                                            STAT_RANGE});
      directed_rows.push_back(req_row_type'{OP_SPARE_7, 5'd2, 5'd3, 32'sd0, 1'b1, 32'sd0,
                                            STAT_OK});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      burst_left = $urandom_range(1, 20);
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i]);
         burst_left--;
         if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         send_word(random_word());
         burst_left--;
         if (n == PAUSE_AT) begin
            // Let the block drain completely before going on.
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_words.size() != 0) @(posedge clock);
         end else if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/masmu_pkg.sv
rtl/masmu_ifs.sv
rtl/masmu_ram.sv
rtl/matrix_add_sub_multiply_unit.sv
rtl/masmu_chk.sv
verif/matrix_add_sub_multiply_unit_test.sv
